/* hw/rtl/cdu_pkg.sv */
// ----------------------------------------------------------------------------
// cdu_pkg
// Shared types, constants and lookup tables for the calendar date unit.
// ----------------------------------------------------------------------------
package cdu_pkg;

  typedef enum logic [1:0] {
    FUNC_TO_SERIAL = 2'd0,
    FUNC_TO_DATE   = 2'd1,
    FUNC_WEEKDAY   = 2'd2,
    FUNC_ROLL      = 2'd3
  } cdu_func_t;

  localparam int PIPE_DEPTH = 19;

  localparam logic [21:0] SERIAL_MAX   = 22'd2958465;
  localparam logic [21:0] QUIRK_SERIAL = 22'd60;
  localparam logic [13:0] QUIRK_YEAR   = 14'd1900;
  localparam logic [13:0] YEAR_MIN     = 14'd1900;
  localparam logic [13:0] YEAR_MAX     = 14'd9999;

  localparam logic [2:0] WD_SUNDAY   = 3'd0;
  localparam logic [2:0] WD_SATURDAY = 3'd6;

  localparam int JD_BIAS    = 2415019;
  localparam int JD_SHIFT   = 32075;
  localparam int JD_FWD     = 68569;
  localparam int YY1_OFS    = 4800;
  localparam int YY2_OFS    = 4900;
  localparam int DAYS_4Y    = 1461;
  localparam int DAYS_400Y  = 146097;
  localparam int DAYS_4000Y = 1461001;
  localparam int I_SCALE    = 4000;
  localparam int DOY_OFS    = 31;
  localparam int CENT_BASE  = 49;

  // floor(x/100) for x < 43690, floor(x/7) for x < 43690
  localparam int RECIP_100 = (2**21 + 99) / 100;
  localparam int RECIP_7   = (2**18 + 6) / 7;
  // underestimating reciprocals, one correction step follows
  localparam int RECIP_N   = (2**25) / DAYS_400Y;
  localparam int RECIP_I   = (2**28) / DAYS_4000Y;

  // floor(367 * mm / 12), mm being the month counted from March
  localparam logic [8:0] MDAY_TAB [16] = '{
    9'((367 * 10) / 12), 9'((367 * 11) / 12), 9'((367 * 12) / 12),
    9'((367 *  1) / 12), 9'((367 *  2) / 12), 9'((367 *  3) / 12),
    9'((367 *  4) / 12), 9'((367 *  5) / 12), 9'((367 *  6) / 12),
    9'((367 *  7) / 12), 9'((367 *  8) / 12), 9'((367 *  9) / 12),
    9'((367 * 10) / 12), 9'((367 * 11) / 12), 9'((367 * 12) / 12),
    9'((367 * 13) / 12)
  };

  localparam logic [2:0] SAK_TAB [16] = '{
    3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1,
    3'd4, 3'd6, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0
  };

  // smallest l with floor(80 * l / 2447) >= k, k = 1..12
  localparam logic [9:0] J_THR [12] = '{
    10'((2447 *  1 + 79) / 80), 10'((2447 *  2 + 79) / 80),
    10'((2447 *  3 + 79) / 80), 10'((2447 *  4 + 79) / 80),
    10'((2447 *  5 + 79) / 80), 10'((2447 *  6 + 79) / 80),
    10'((2447 *  7 + 79) / 80), 10'((2447 *  8 + 79) / 80),
    10'((2447 *  9 + 79) / 80), 10'((2447 * 10 + 79) / 80),
    10'((2447 * 11 + 79) / 80), 10'((2447 * 12 + 79) / 80)
  };

  // floor(2447 * j / 80)
  localparam logic [9:0] D_TAB [16] = '{
    10'((2447 *  0) / 80), 10'((2447 *  1) / 80), 10'((2447 *  2) / 80),
    10'((2447 *  3) / 80), 10'((2447 *  4) / 80), 10'((2447 *  5) / 80),
    10'((2447 *  6) / 80), 10'((2447 *  7) / 80), 10'((2447 *  8) / 80),
    10'((2447 *  9) / 80), 10'((2447 * 10) / 80), 10'((2447 * 11) / 80),
    10'((2447 * 12) / 80), 10'd0, 10'd0, 10'd0
  };

endpackage

/* hw/rtl/cdu_if.sv */
// ----------------------------------------------------------------------------
// cdu_if
// Valid/ready channels of the calendar date unit: request and result.
// ----------------------------------------------------------------------------
interface cdu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [21:0] serial;

  modport source (output valid, func, day, month, year, serial, input ready);
  modport sink   (input valid, func, day, month, year, serial, output ready);
endinterface

interface cdu_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [13:0] out_year;
  logic [21:0] out_serial;
  logic [2:0]  weekday;
  logic        range_error;

  modport source (output valid, out_day, out_month, out_year, out_serial, weekday,
                  range_error, input ready);
  modport sink   (input valid, out_day, out_month, out_year, out_serial, weekday,
                  range_error, output ready);
endinterface

/* hw/rtl/calendar_date_unit_top.sv */
// ----------------------------------------------------------------------------
// calendar_date_unit_top
// Date/serial conversion, weekday and weekend roll, 19-stage pipeline.
// ----------------------------------------------------------------------------
// One request beat per clock unless every stage is full and out_if.ready is
// low, one result beat per request, in order. The depth comes from the
// serial-to-date path, where the divisions by 146097 and 1461001 are each a
// reciprocal multiply, a back-multiply and a one-step correction, each in a
// stage of its own. Every stage holds a valid bit and loads whenever it or
// some stage after it is empty, so bubbles close up and requests are still
// taken while a finished result waits on out_if.ready.
module calendar_date_unit_top import cdu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  cdu_in_if.sink   in_if,
  cdu_out_if.source out_if
);

  localparam int LAST = PIPE_DEPTH - 1;

  typedef logic [PIPE_DEPTH-1:0] stg_vec_t;

  typedef struct packed {
    cdu_func_t   func;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] serial_in;
    logic        quirk;
    logic        date_ok;
    logic [14:0] yy1;
    logic [14:0] yy2;
    logic [8:0]  t2;
    logic [13:0] yw;
    logic [2:0]  sak;
    logic [24:0] p1;
    logic [28:0] p100;
    logic [28:0] pw100;
    logic [22:0] t1s;
    logic [7:0]  t3;
    logic [14:0] ws;
    logic [23:0] sv;
    logic [29:0] pw7;
    logic [2:0]  wd;
    logic        conv;
    logic [21:0] sx;
    logic        qk;
    logic [22:0] l;
    logic [32:0] pn;
    logic [7:0]  n;
    logic [25:0] mn;
    logic [15:0] l2;
    logic [27:0] xi;
    logic [34:0] pi;
    logic [6:0]  i;
    logic [27:0] mi;
    logic [17:0] mi2;
    logic [9:0]  l3;
    logic [3:0]  j;
    logic        err;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic [21:0] r_serial;
    logic [2:0]  r_wd;
  } cdu_work_t;

  stg_vec_t  v_r;
  stg_vec_t  v_nxt;
  stg_vec_t  stg_en;
  cdu_work_t w_r   [PIPE_DEPTH];
  cdu_work_t w_nxt [PIPE_DEPTH];

  logic        early;
  logic [7:0]  cw;
  logic [11:0] q7;
  logic [23:0] roll_sv;
  logic [21:0] sx_adj;
  logic [25:0] rn;
  logic [27:0] ri;
  logic [3:0]  j_cnt;
  logic        l4;
  logic [3:0]  jm;

  // a stage loads when it or any stage after it is empty
  always_comb begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      stg_en[k] = out_if.ready || !(&(v_r | stg_vec_t'((1 << k) - 1)));
    end
    v_nxt = {v_r[PIPE_DEPTH-2:0], in_if.valid};
  end

  assign in_if.ready = stg_en[0];

  always_comb begin
    // input decode
    early = (in_if.month <= 4'd2);
    w_nxt[0]           = '0;
    w_nxt[0].func      = cdu_func_t'(in_if.func);
    w_nxt[0].day       = in_if.day;
    w_nxt[0].month     = in_if.month;
    w_nxt[0].year      = in_if.year;
    w_nxt[0].serial_in = in_if.serial;
    w_nxt[0].quirk     = (in_if.day == 5'd29) && (in_if.month == 4'd2) &&
                         (in_if.year == QUIRK_YEAR);
    w_nxt[0].date_ok   = (in_if.day != 5'd0) && (in_if.month >= 4'd1) &&
                         (in_if.month <= 4'd12) && (in_if.year >= YEAR_MIN) &&
                         (in_if.year <= YEAR_MAX);
    w_nxt[0].yy1 = 15'(in_if.year) + 15'(YY1_OFS) - 15'(early);
    w_nxt[0].yy2 = 15'(in_if.year) + 15'(YY2_OFS) - 15'(early);
    w_nxt[0].t2  = MDAY_TAB[in_if.month];
    w_nxt[0].yw  = early ? in_if.year - 14'd1 : in_if.year;
    w_nxt[0].sak = SAK_TAB[in_if.month - 4'd1];

    // year products
    w_nxt[1]       = w_r[0];
    w_nxt[1].p1    = 25'(w_r[0].yy1) * 25'(DAYS_4Y);
    w_nxt[1].p100  = 29'(w_r[0].yy2) * 29'(RECIP_100);
    w_nxt[1].pw100 = 29'(w_r[0].yw) * 29'(RECIP_100);

    // partial sums
    cw = w_r[1].pw100[28:21];
    w_nxt[2]     = w_r[1];
    w_nxt[2].t1s = 23'(w_r[1].p1[24:2]) + 23'(w_r[1].t2) + 23'(w_r[1].day);
    w_nxt[2].t3  = 8'((10'(w_r[1].p100[28:21]) * 10'd3) >> 2);
    w_nxt[2].ws  = 15'(w_r[1].yw) + 15'(w_r[1].yw[13:2]) - 15'(cw) +
                   15'(cw[7:2]) + 15'(w_r[1].sak) + 15'(w_r[1].day);

    // raw serial, weekday reciprocal
    w_nxt[3]     = w_r[2];
    w_nxt[3].sv  = 24'(w_r[2].t1s) - 24'(w_r[2].t3) - 24'(JD_BIAS + JD_SHIFT);
    w_nxt[3].pw7 = 30'(w_r[2].ws) * 30'(RECIP_7);

    // leap-year quirk, weekday remainder
    q7 = w_r[3].pw7[29:18];
    w_nxt[4]    = w_r[3];
    w_nxt[4].wd = 3'(w_r[3].ws - 15'(q7) * 15'd7);
    if (w_r[3].quirk) begin
      w_nxt[4].sv = 24'(QUIRK_SERIAL);
    end else if ($signed(w_r[3].sv) <= $signed(24'(QUIRK_SERIAL))) begin
      w_nxt[4].sv = w_r[3].sv - 24'd1;
    end

    // per-function result and range checks
    roll_sv  = w_r[4].sv + ((w_r[4].wd == WD_SUNDAY) ? 24'd1 : 24'd2);
    w_nxt[5] = w_r[4];
    unique case (w_r[4].func)
      FUNC_TO_SERIAL: begin
        if ($signed(w_r[4].sv) < 0 ||
            $signed(w_r[4].sv) > $signed(24'(SERIAL_MAX))) begin
          w_nxt[5].err = 1'b1;
        end else begin
          w_nxt[5].r_serial = w_r[4].sv[21:0];
        end
      end
      FUNC_TO_DATE: begin
        if (w_r[4].serial_in == 22'd0 || w_r[4].serial_in > SERIAL_MAX) begin
          w_nxt[5].err = 1'b1;
        end else begin
          w_nxt[5].conv = 1'b1;
          w_nxt[5].sx   = w_r[4].serial_in;
        end
      end
      FUNC_WEEKDAY: begin
        if (!w_r[4].date_ok) begin
          w_nxt[5].err = 1'b1;
        end else begin
          w_nxt[5].r_wd = w_r[4].wd;
        end
      end
      FUNC_ROLL: begin
        if (!w_r[4].date_ok) begin
          w_nxt[5].err = 1'b1;
        end else if (w_r[4].wd == WD_SUNDAY || w_r[4].wd == WD_SATURDAY) begin
          if ($signed(roll_sv) < 1 || $signed(roll_sv) > $signed(24'(SERIAL_MAX))) begin
            w_nxt[5].err = 1'b1;
          end else begin
            w_nxt[5].conv = 1'b1;
            w_nxt[5].sx   = roll_sv[21:0];
          end
        end else begin
          w_nxt[5].r_day   = w_r[4].day;
          w_nxt[5].r_month = w_r[4].month;
          w_nxt[5].r_year  = w_r[4].year;
        end
      end
      default: w_nxt[5].err = 1'b1;
    endcase

    // back to the plain Julian count
    sx_adj   = (w_r[5].sx < QUIRK_SERIAL) ? w_r[5].sx + 22'd1 : w_r[5].sx;
    w_nxt[6]    = w_r[5];
    w_nxt[6].qk = (w_r[5].sx == QUIRK_SERIAL);
    w_nxt[6].l  = 23'(sx_adj) + 23'(JD_BIAS + JD_FWD);

    // n = 4l / 146097
    w_nxt[7]    = w_r[6];
    w_nxt[7].pn = 33'({w_r[6].l, 2'b00}) * 33'(RECIP_N);

    w_nxt[8]    = w_r[7];
    w_nxt[8].n  = w_r[7].pn[32:25];
    w_nxt[8].mn = 26'(w_r[7].pn[32:25]) * 26'(DAYS_400Y);

    rn = 26'({w_r[8].l, 2'b00}) - w_r[8].mn;
    w_nxt[9] = w_r[8];
    if (rn >= 26'(DAYS_400Y)) begin
      w_nxt[9].n  = w_r[8].n + 8'd1;
      w_nxt[9].mn = w_r[8].mn + 26'(DAYS_400Y);
    end

    w_nxt[10]    = w_r[9];
    w_nxt[10].l2 = 16'(w_r[9].l - 23'((w_r[9].mn + 26'd3) >> 2));

    // i = 4000 (l2 + 1) / 1461001
    w_nxt[11]    = w_r[10];
    w_nxt[11].xi = 28'({1'b0, w_r[10].l2} + 17'd1) * 28'(I_SCALE);

    w_nxt[12]    = w_r[11];
    w_nxt[12].pi = 35'(w_r[11].xi) * 35'(RECIP_I);

    w_nxt[13]    = w_r[12];
    w_nxt[13].i  = w_r[12].pi[34:28];
    w_nxt[13].mi = 28'(w_r[12].pi[34:28]) * 28'(DAYS_4000Y);

    ri = w_r[13].xi - w_r[13].mi;
    w_nxt[14] = w_r[13];
    if (ri >= 28'(DAYS_4000Y)) begin
      w_nxt[14].i = w_r[13].i + 7'd1;
    end

    w_nxt[15]     = w_r[14];
    w_nxt[15].mi2 = 18'(w_r[14].i) * 18'(DAYS_4Y);

    w_nxt[16]    = w_r[15];
    w_nxt[16].l3 = 10'(w_r[15].l2 - 16'(w_r[15].mi2 >> 2) + 16'(DOY_OFS));

    // j = 80 l3 / 2447 against fixed thresholds
    j_cnt = 4'd0;
    for (int k = 0; k < 12; k++) begin
      if (w_r[16].l3 >= J_THR[k]) begin
        j_cnt = 4'(k + 1);
      end
    end
    w_nxt[17]   = w_r[16];
    w_nxt[17].j = j_cnt;

    // date assembly
    l4 = (w_r[17].j >= 4'd11);
    jm = l4 ? w_r[17].j - 4'd10 : w_r[17].j + 4'd2;
    w_nxt[18] = w_r[17];
    if (w_r[17].conv) begin
      if (w_r[17].qk) begin
        w_nxt[18].r_day   = 5'd29;
        w_nxt[18].r_month = 4'd2;
        w_nxt[18].r_year  = QUIRK_YEAR;
      end else begin
        w_nxt[18].r_day   = 5'(w_r[17].l3 - D_TAB[w_r[17].j]);
        w_nxt[18].r_month = jm;
        w_nxt[18].r_year  = 14'(w_r[17].n - 8'(CENT_BASE)) * 14'd100 +
                            14'(w_r[17].i) + 14'(l4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (stg_en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (stg_en[k]) begin
        w_r[k] <= w_nxt[k];
      end
    end
  end

  assign out_if.valid       = v_r[LAST];
  assign out_if.out_day     = w_r[LAST].r_day;
  assign out_if.out_month   = w_r[LAST].r_month;
  assign out_if.out_year    = w_r[LAST].r_year;
  assign out_if.out_serial  = w_r[LAST].r_serial;
  assign out_if.weekday     = w_r[LAST].r_wd;
  assign out_if.range_error = w_r[LAST].err;

endmodule

/* hw/rtl/cdu_checker.sv */
// ----------------------------------------------------------------------------
// cdu_checker
// Port-level checks of the calendar date unit, bound to the top level.
// ----------------------------------------------------------------------------
module cdu_checker import cdu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_day,
  input logic [3:0]  out_month,
  input logic [13:0] out_year,
  input logic [21:0] out_serial,
  input logic [2:0]  weekday,
  input logic        range_error
);

  logic [5:0] inflight_r;
  logic [5:0] inflight_nxt;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r + 6'(in_beat) - 6'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_day, out_month, out_year, out_serial, weekday, range_error}))
    else $error("result beat changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 6'd0)
    else $error("result beat without a pending request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 6'(PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && range_error |-> out_day == 5'd0 && out_month == 4'd0 &&
      out_year == 14'd0 && out_serial == 22'd0 && weekday == 3'd0)
    else $error("range error with nonzero result fields");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> weekday <= WD_SATURDAY && out_serial <= SERIAL_MAX &&
      (out_serial == 22'd0 || (out_day == 5'd0 && out_month == 4'd0 &&
       out_year == 14'd0 && weekday == 3'd0)))
    else $error("result fields out of range or mixed");

endmodule

bind calendar_date_unit_top cdu_checker u_cdu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_day     (out_if.out_day),
  .out_month   (out_if.out_month),
  .out_year    (out_if.out_year),
  .out_serial  (out_if.out_serial),
  .weekday     (out_if.weekday),
  .range_error (out_if.range_error)
);
